@@ hdl/qtmd_pkg.sv @@
// shared constants and types for the quadrature trapezoid move driver
`timescale 1ns / 1ps
`default_nettype none

package qtmd_pkg;

  // default width of the internal encoder count
  localparam int unsigned POSITION_BITS_DEF = 24;

  // field widths
  localparam int unsigned ANG_W     = 10;
  localparam int unsigned DUTY_W    = 15;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned RAMP_W    = 2;
  localparam int unsigned POS_OUT_W = 24;
  localparam int unsigned TDATA_W   = 48;
  localparam int unsigned CFG_IDX_W = 2;

  // angle to counts: q = (|angle| * counts_per_rev + 180) / 360
  localparam int unsigned MAG_W      = ANG_W + CFG_W - 1;
  localparam int unsigned ROUND_BIAS = 180;
  // divide by 360 as a shift by 3 and a reciprocal multiply by 1/45
  localparam int unsigned PRE_SHIFT   = 3;
  localparam int unsigned Y_W         = MAG_W - PRE_SHIFT;
  localparam int unsigned RECIP_W     = 23;
  localparam int unsigned RECIP_SHIFT = 28;
  // ceil(2^28 / 45), exact for any dividend below 2^22
  localparam logic [RECIP_W-1:0] RECIP45 = RECIP_W'(5965233);
  localparam int unsigned Q_W    = 17;
  localparam int unsigned GOAL_W = Q_W + 1;
  localparam logic [Q_W-1:0] Q_MAX = Q_W'(((2 ** MAG_W) - 1 + ROUND_BIAS) / 360);

  // register reset values
  localparam logic [CFG_W-1:0]  CPR_RST  = CFG_W'(5264);
  localparam logic [CFG_W-1:0]  TOL_RST  = CFG_W'(15);
  localparam logic              NEG_RST  = 1'b1;
  localparam logic [RAMP_W-1:0] RAMP_RST = RAMP_W'(1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CPR  = 2'd0,
    CFG_TOL  = 2'd1,
    CFG_NEG  = 2'd2,
    CFG_RAMP = 2'd3
  } cfg_reg_e;

endpackage

`default_nettype wire

@@ hdl/quadrature_trapezoid_move_driver.sv @@
// quadrature counter with a trapezoidal duty profile, top level
//
// Each input item on the s_axis channel is one clock sample of the encoder
// lines together with an optional move start and a profile tick; each item
// gives exactly one result item on m_axis with duty, direction, busy flag,
// position count and a move-done pulse.
// The cfg channel writes the four profile registers; it is always ready and
// should be used only while no item is in flight.
// The result passes four register stages after the item is accepted: input
// register, multiplier stage, reciprocal divide stage, profile and result
// register. Throughput: one item per cycle while m_axis is ready, as the
// four register stages each take a new item every clock unless stalled.
// A stalled m_axis holds the result register; upstream stages keep filling
// empty slots, and s_axis_tready drops only once all four stages are full.
// Reset clears the encoder count, the move state and the duty level, and
// loads the registers with counts_per_rev 5264, tolerance 15, negated
// position and ramp step 1.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_trapezoid_move_driver
  import qtmd_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input items
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  // enc_a, enc_b, start_move, target_angle[9:0], duty_max[14:0],
  // duty_min[14:0], profile_tick, zero fill
  input  wire logic [TDATA_W-1:0]   s_axis_tdata,
  // result items
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // duty_us[14:0], drive_dir, busy_res, position_count[23:0], move_done,
  // zero fill
  output      logic [TDATA_W-1:0]   m_axis_tdata,
  // register writes
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned MP_W = POSITION_BITS + 1;
  localparam int unsigned E_W  = POSITION_BITS + 2;
  localparam int unsigned T_W  = E_W + 1;
  localparam int unsigned T3_W = E_W + 3;
  localparam int unsigned PRODQ_W = Y_W + RECIP_W;

  // configuration registers
  logic [CFG_W-1:0]  cpr_q, tol_q;
  logic              neg_q;
  logic [RAMP_W-1:0] ramp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q  <= CPR_RST;
      tol_q  <= TOL_RST;
      neg_q  <= NEG_RST;
      ramp_q <= RAMP_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_CPR:  cpr_q  <= cfg_data_i;
        CFG_TOL:  tol_q  <= cfg_data_i;
        CFG_NEG:  neg_q  <= cfg_data_i[0];
        CFG_RAMP: ramp_q <= cfg_data_i[RAMP_W-1:0];
        default:  cpr_q  <= cpr_q;
      endcase
    end
  end

  // pipeline valids and flow control
  logic va_q, vb_q, vc_q, vo_q;
  logic ra, rb, rc, ro;
  logic mv_in, mv_ab, mv_bc, mv_co;

  assign ro = !vo_q || m_axis_tready;
  assign rc = !vc_q || ro;
  assign rb = !vb_q || rc;
  assign ra = !va_q || rb;
  assign s_axis_tready = ra;
  assign mv_in = s_axis_tvalid && ra;
  assign mv_ab = va_q && rb;
  assign mv_bc = vb_q && rc;
  assign mv_co = vc_q && ro;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ra) va_q <= s_axis_tvalid;
      if (rb) vb_q <= va_q;
      if (rc) vc_q <= vb_q;
      if (ro) vo_q <= vc_q;
    end
  end

  // stage a: input register
  logic                    a_enc_a_q, a_enc_b_q, a_start_q, a_tick_q;
  logic signed [ANG_W-1:0] a_ang_q;
  logic [DUTY_W-1:0]       a_dmax_q, a_dmin_q;

  always_ff @(posedge clk_i) begin
    if (mv_in) begin
      a_enc_a_q <= s_axis_tdata[0];
      a_enc_b_q <= s_axis_tdata[1];
      a_start_q <= s_axis_tdata[2];
      a_ang_q   <= s_axis_tdata[12:3];
      a_dmax_q  <= s_axis_tdata[27:13];
      a_dmin_q  <= s_axis_tdata[42:28];
      a_tick_q  <= s_axis_tdata[43];
    end
  end

  // stage b: quadrature decode, count update, angle times counts_per_rev
  logic                            last_a_q, last_b_q;
  logic signed [POSITION_BITS-1:0] enc_q, enc_d;
  logic                            ch_a, ch_b, step_up, step_dn;
  logic [ANG_W-1:0]                ang_abs;
  logic signed [MP_W-1:0]          mp_d;

  always_comb begin
    ch_a    = a_enc_a_q ^ last_a_q;
    ch_b    = a_enc_b_q ^ last_b_q;
    step_up = 1'b0;
    step_dn = 1'b0;
    if (ch_a && !ch_b) begin
      step_up = a_enc_a_q ^ a_enc_b_q;
      step_dn = !(a_enc_a_q ^ a_enc_b_q);
    end else if (ch_b && !ch_a) begin
      step_up = !(a_enc_a_q ^ a_enc_b_q);
      step_dn = a_enc_a_q ^ a_enc_b_q;
    end
    enc_d = enc_q;
    if (step_up) enc_d = enc_q + POSITION_BITS'(1);
    else if (step_dn) enc_d = enc_q - POSITION_BITS'(1);
    mp_d    = neg_q ? -MP_W'(enc_d) : MP_W'(enc_d);
    ang_abs = a_ang_q[ANG_W-1] ? ANG_W'(-a_ang_q) : ANG_W'(a_ang_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_a_q <= 1'b0;
      last_b_q <= 1'b0;
      enc_q    <= '0;
    end else if (mv_ab) begin
      last_a_q <= a_enc_a_q;
      last_b_q <= a_enc_b_q;
      enc_q    <= enc_d;
    end
  end

  logic                   b_start_q, b_tick_q, b_ang_neg_q;
  logic [DUTY_W-1:0]      b_dmax_q, b_dmin_q;
  logic [MAG_W-1:0]       b_mag_q;
  logic signed [MP_W-1:0] b_mp_q;

  always_ff @(posedge clk_i) begin
    if (mv_ab) begin
      b_start_q   <= a_start_q;
      b_tick_q    <= a_tick_q;
      b_ang_neg_q <= a_ang_q[ANG_W-1];
      b_dmax_q    <= a_dmax_q;
      b_dmin_q    <= a_dmin_q;
      b_mag_q     <= MAG_W'(ang_abs) * MAG_W'(cpr_q);
      b_mp_q      <= mp_d;
    end
  end

  // stage c: rounded divide by 360 and goal sign
  logic [MAG_W-1:0]         mag_round;
  logic [Y_W-1:0]           y_div;
  logic [PRODQ_W-1:0]       prod_q;
  logic [Q_W-1:0]           q_d;
  logic signed [GOAL_W-1:0] goal_c_d;

  always_comb begin
    mag_round = b_mag_q + MAG_W'(ROUND_BIAS);
    y_div     = mag_round[MAG_W-1:PRE_SHIFT];
    prod_q    = PRODQ_W'(y_div) * PRODQ_W'(RECIP45);
    q_d       = prod_q[RECIP_SHIFT +: Q_W];
    goal_c_d  = b_ang_neg_q ? -GOAL_W'(q_d) : GOAL_W'(q_d);
  end

  logic                            c_start_q, c_tick_q;
  logic [DUTY_W-1:0]               c_dmax_q, c_dmin_q;
  logic signed [GOAL_W-1:0]        c_goal_q;
  logic signed [MP_W-1:0]          c_mp_q;
  logic signed [POSITION_BITS-1:0] c_enc_q;

  always_ff @(posedge clk_i) begin
    if (mv_bc) begin
      c_start_q <= b_start_q;
      c_tick_q  <= b_tick_q;
      c_dmax_q  <= b_dmax_q;
      c_dmin_q  <= b_dmin_q;
      c_goal_q  <= goal_c_d;
      c_mp_q    <= b_mp_q;
      c_enc_q   <= enc_q;
    end
  end

  // stage d: start and tick handling of the move state
  logic signed [GOAL_W-1:0] goal_q, goal_d;
  logic signed [E_W-1:0]    span_q, span_d;
  logic [E_W-1:0]           sabs_q, sabs_d;
  logic [DUTY_W-1:0]        lvl_q, lvl_d;
  logic                     dir_q, dir_d, mov_q, mov_d, done_d;
  logic signed [E_W-1:0]    e_start, e_state, e_tick;
  logic [E_W-1:0]           eabs_tick, tol_ext;
  logic signed [T_W-1:0]    trav_diff;
  logic [T_W-1:0]           trav;
  logic [T3_W-1:0]          trav3, sabs1, sabs2;
  logic [DUTY_W-1:0]        ramp_ext;

  always_comb begin
    tol_ext  = E_W'(tol_q);
    ramp_ext = DUTY_W'(ramp_q);
    e_start  = E_W'(c_goal_q) - E_W'(c_mp_q);
    e_state  = E_W'(goal_q) - E_W'(c_mp_q);
    goal_d   = goal_q;
    span_d   = span_q;
    sabs_d   = sabs_q;
    mov_d    = mov_q;
    dir_d    = dir_q;
    lvl_d    = lvl_q;
    done_d   = 1'b0;
    // new move request
    if (c_start_q) begin
      goal_d = c_goal_q;
      span_d = e_start;
      sabs_d = e_start[E_W-1] ? E_W'(-e_start) : E_W'(e_start);
      if (sabs_d > tol_ext) begin
        mov_d = 1'b1;
      end else begin
        mov_d  = 1'b0;
        done_d = 1'b1;
      end
    end
    // profile step
    e_tick    = c_start_q ? e_start : e_state;
    eabs_tick = e_tick[E_W-1] ? E_W'(-e_tick) : E_W'(e_tick);
    trav_diff = T_W'(span_d) - T_W'(e_tick);
    trav      = trav_diff[T_W-1] ? T_W'(-trav_diff) : T_W'(trav_diff);
    trav3     = (T3_W'(trav) << 1) + T3_W'(trav);
    sabs1     = T3_W'(sabs_d);
    sabs2     = T3_W'(sabs_d) << 1;
    if (c_tick_q && mov_d) begin
      if (eabs_tick <= tol_ext) begin
        mov_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        dir_d = !e_tick[E_W-1];
        if (trav3 < sabs1) begin
          // first third: ramp up
          if (lvl_q < c_dmax_q) lvl_d = lvl_q + DUTY_W'(1);
        end else if (trav3 < sabs2) begin
          // middle third: hold at peak
          lvl_d = c_dmax_q;
        end else if (T3_W'(trav) <= sabs1) begin
          // last third: ramp down, saturating at zero
          if (lvl_q > c_dmin_q) lvl_d = (lvl_q > ramp_ext) ? lvl_q - ramp_ext : '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q <= '0;
      span_q <= '0;
      sabs_q <= '0;
      lvl_q  <= '0;
      dir_q  <= 1'b0;
      mov_q  <= 1'b0;
    end else if (mv_co) begin
      goal_q <= goal_d;
      span_q <= span_d;
      sabs_q <= sabs_d;
      lvl_q  <= lvl_d;
      dir_q  <= dir_d;
      mov_q  <= mov_d;
    end
  end

  // result register
  logic signed [31:0]     enc_ext;
  logic [DUTY_W-1:0]      out_duty_q;
  logic                   out_dir_q, out_busy_q, out_done_q;
  logic [POS_OUT_W-1:0]   out_pos_q;

  assign enc_ext = 32'(c_enc_q);

  always_ff @(posedge clk_i) begin
    if (mv_co) begin
      out_duty_q <= mov_d ? lvl_d : '0;
      out_dir_q  <= dir_d;
      out_busy_q <= mov_d;
      out_pos_q  <= enc_ext[POS_OUT_W-1:0];
      out_done_q <= done_d;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {6'b0, out_done_q, out_pos_q, out_busy_q, out_dir_q, out_duty_q};

  // a move that just ended never reports busy in the same item
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(out_done_q && out_busy_q))
    else $error("move_done and busy_res both set");

  // reciprocal divide stays within the reachable goal range
  a_goal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q |-> (q_d <= Q_MAX))
    else $error("goal quotient out of range");

  // the encoder count moves only when an item enters stage b
  a_enc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (enc_q != $past(enc_q)) |-> $past(mv_ab))
    else $error("encoder count changed without an item");

  // an idle result never drives a duty
  a_idle_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_busy_q) |-> (out_duty_q == '0))
    else $error("nonzero duty while idle");

endmodule

`default_nettype wire
